FILE: rtl/msig_pkg.sv
// Package with the payload types, the built-in signature table and shared helper functions.
`timescale 1ns / 1ps

package msig_pkg;

    localparam int SIG_SLOTS     = 8;
    localparam int SIG_MAX_BYTES = 12;

    localparam int WINDOW_BYTES_DEF   = 12;
    localparam int NUM_SIGNATURES_DEF = 8;
    localparam int OFFSET_BITS_DEF    = 32;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  pattern_id;
        logic [31:0] match_offset;
        logic [1:0]  pattern_class;
        logic [1:0]  version_code;
        logic        is_protected;
        logic        offset_saturated;
        logic        last_result;
    } out_t;

    // Hand-over from the window stage to the result emitter.
    typedef struct packed {
        logic                 last;
        logic                 sat;
        logic [SIG_SLOTS-1:0] hits;
    } scan_load_t;

    localparam logic [3:0] SIG_LEN [SIG_SLOTS] = '{
        4'd9, 4'd9, 4'd9, 4'd11, 4'd11, 4'd12, 4'd4, 4'd9
    };
    localparam logic [1:0] SIG_CLASS [SIG_SLOTS] = '{
        2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0
    };
    localparam logic [1:0] SIG_VERSION [SIG_SLOTS] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0
    };

    localparam logic [7:0] SIG_PAT [SIG_SLOTS][SIG_MAX_BYTES] = '{
        '{8'h60, 8'hE8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5D, 8'h81, 8'hED, 8'h00, 8'h00, 8'h00},
        '{8'h8B, 8'h44, 8'h24, 8'h04, 8'h8B, 8'h00, 8'h8B, 8'h40, 8'h04, 8'h00, 8'h00, 8'h00},
        '{8'h55, 8'h8B, 8'hEC, 8'h83, 8'hEC, 8'h10, 8'h53, 8'h56, 8'h57, 8'h00, 8'h00, 8'h00},
        '{8'h8B, 8'h45, 8'h08, 8'h8B, 8'h00, 8'h8B, 8'h40, 8'h08, 8'h89, 8'h45, 8'hFC, 8'h00},
        '{8'h48, 8'h83, 8'hEC, 8'h28, 8'h48, 8'h8B, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h8B, 8'h44, 8'h24, 8'h08, 8'h48, 8'h8B, 8'h00, 8'h48, 8'h8B, 8'h40, 8'h08},
        '{8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h56, 8'h4D, 8'h50, 8'h72, 8'h6F, 8'h74, 8'h65, 8'h63, 8'h74, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] SIG_MASK [SIG_SLOTS][SIG_MAX_BYTES] = '{
        '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}
    };

    // Window position j holds the byte taken j transactions ago, so it is compared
    // with signature byte len-1-j. Positions beyond the signature always agree.
    function automatic logic sig_byte_hit(input logic [2:0] s, input int unsigned j,
                                          input logic [7:0] b);
        int unsigned len;
        logic [3:0]  k;
        logic        r;
        len = int'(SIG_LEN[s]);
        r   = 1'b1;
        if (j < len) begin
            k = 4'(len - 1 - j);
            r = ((b ^ SIG_PAT[s][k]) & SIG_MASK[s][k]) == 8'h00;
        end
        return r;
    endfunction

    // Version of the lowest-indexed versioned signature in the set, zero if none.
    function automatic logic [1:0] first_version(input logic [SIG_SLOTS-1:0] seen);
        logic [1:0] v;
        logic       found;
        v     = 2'd0;
        found = 1'b0;
        for (int s = 0; s < SIG_SLOTS; s++) begin
            if (!found && seen[s] && SIG_VERSION[s] != 2'd0) begin
                v     = SIG_VERSION[s];
                found = 1'b1;
            end
        end
        return v;
    endfunction

endpackage

FILE: rtl/msig_cell.sv
// One window cell: holds a byte, passes it on at each shift and compares it with the table.
`timescale 1ns / 1ps

module msig_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                shift_en,
    input  logic [7:0]                          byte_in,
    output logic [7:0]                          byte_out,
    output logic [msig_pkg::SIG_SLOTS-1:0]      hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift_en ? byte_in : byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

    always_comb begin
        for (int s = 0; s < msig_pkg::SIG_SLOTS; s++) begin
            hit[s] = msig_pkg::sig_byte_hit(3'(s), CELL_INDEX, byte_reg);
        end
    end

endmodule

FILE: rtl/msig_emitter.sv
// Result emitter: turns one byte's match set and summary into a run of result transactions.
`timescale 1ns / 1ps

module msig_emitter #(
    parameter int OFFSET_BITS = msig_pkg::OFFSET_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_valid,
    output logic                       load_ready,
    input  msig_pkg::scan_load_t       load_info,
    input  logic [OFFSET_BITS-1:0]     load_pos,
    output logic                       m_valid,
    input  logic                       m_ready,
    output msig_pkg::out_t             m_data
);

    localparam int SLOTS = msig_pkg::SIG_SLOTS;

    logic [SLOTS-1:0]       pend_reg,  pend_next;
    logic                   sum_reg,   sum_next;
    logic [SLOTS-1:0]       seen_reg,  seen_next;
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic                   sat_reg,   sat_next;
    logic [1:0]             ver_reg,   ver_next;
    logic                   prot_reg,  prot_next;

    logic [2:0]             cur_id;
    logic [SLOTS-1:0]       pend_rest;
    logic                   final_out;
    logic                   pop;
    logic                   load;
    logic [SLOTS-1:0]       seen_acc;
    logic [OFFSET_BITS-1:0] off_full;
    logic [63:0]            off_wide;

    always_comb begin
        logic found;
        found  = 1'b0;
        cur_id = 3'd0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!found && pend_reg[s]) begin
                cur_id = 3'(s);
                found  = 1'b1;
            end
        end
    end

    assign pend_rest = pend_reg & (pend_reg - SLOTS'(1));
    assign m_valid   = (pend_reg != '0) || sum_reg;
    assign final_out = (pend_reg == '0) || ((pend_rest == '0) && !sum_reg);
    assign pop       = m_valid && m_ready;

    // A new set may enter once the current run hands over its final transaction.
    assign load_ready = !m_valid || (m_ready && final_out);
    assign load       = load_valid && load_ready;

    assign off_full = pos_reg - OFFSET_BITS'(msig_pkg::SIG_LEN[cur_id] - 4'd1);
    assign off_wide = 64'(off_full);

    always_comb begin
        m_data.offset_saturated = sat_reg;
        m_data.last_result      = final_out;
        if (pend_reg != '0) begin
            m_data.result_kind   = msig_pkg::KIND_MATCH;
            m_data.pattern_id    = cur_id;
            m_data.match_offset  = off_wide[31:0];
            m_data.pattern_class = msig_pkg::SIG_CLASS[cur_id];
            m_data.version_code  = msig_pkg::SIG_VERSION[cur_id];
            m_data.is_protected  = 1'b0;
        end else begin
            m_data.result_kind   = msig_pkg::KIND_SUMMARY;
            m_data.pattern_id    = 3'd0;
            m_data.match_offset  = 32'd0;
            m_data.pattern_class = 2'd0;
            m_data.version_code  = ver_reg;
            m_data.is_protected  = prot_reg;
        end
    end

    assign seen_acc = seen_reg | load_info.hits;

    always_comb begin
        pend_next = pend_reg;
        sum_next  = sum_reg;
        seen_next = seen_reg;
        pos_next  = pos_reg;
        sat_next  = sat_reg;
        ver_next  = ver_reg;
        prot_next = prot_reg;
        if (pop) begin
            if (pend_reg != '0) begin
                pend_next = pend_rest;
            end else begin
                sum_next = 1'b0;
            end
        end
        if (load) begin
            pend_next = load_info.hits;
            sum_next  = load_info.last;
            pos_next  = load_pos;
            sat_next  = load_info.sat;
            if (load_info.last) begin
                ver_next  = msig_pkg::first_version(seen_acc);
                prot_next = seen_acc != '0;
                seen_next = '0;
            end else begin
                seen_next = seen_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            sum_reg  <= 1'b0;
            seen_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            sum_reg  <= sum_next;
            seen_reg <= seen_next;
        end
        pos_reg  <= pos_next;
        sat_reg  <= sat_next;
        ver_reg  <= ver_next;
        prot_reg <= prot_next;
    end

endmodule

FILE: rtl/masked_signature_scanner.sv
// Top level of the masked byte-signature scanner: window cell chain, position counter, emitter.
`timescale 1ns / 1ps

// The block scans a binary streamed one byte per s_ transaction; s_data.last_byte marks
// the final byte. For each byte it issues one m_ transaction for every enabled signature
// that completes there, in ascending pattern_id, and after the final byte a summary
// transaction; m_data.last_result marks the last transaction a byte causes. A byte that
// completes nothing and is not the final byte causes no transaction.
// The first result of a byte is registered in the window stage and then in the emitter.
// While the receiver takes every result, a byte with at most one result sustains one
// byte per cycle; a byte with several results holds the emitter until its final result
// is taken, and input is held off until then. The rate is set by the emitter's single
// output port. The window is a chain of cells that shift on every accepted byte; each
// cell compares its byte with all signatures at once.
// The user must write pattern_enable through cfg_wr_en and cfg_wr_data only while the
// block is idle; the block itself does not enforce it. Reset clears the window, the
// position counter and the seen set, and enables all signatures, with no clearing pass.
// When the receiver stalls, results wait in the emitter, one byte waits in the window
// stage, and then s_ready falls.
module masked_signature_scanner #(
    parameter int WINDOW_BYTES   = msig_pkg::WINDOW_BYTES_DEF,
    parameter int NUM_SIGNATURES = msig_pkg::NUM_SIGNATURES_DEF,
    parameter int OFFSET_BITS    = msig_pkg::OFFSET_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  msig_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output msig_pkg::out_t  m_data,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data
);

    localparam int SLOTS = msig_pkg::SIG_SLOTS;
    localparam logic [OFFSET_BITS-1:0] POS_LIMIT = {OFFSET_BITS{1'b1}};

    logic [7:0]             enable_reg;
    logic [OFFSET_BITS-1:0] pos_reg,     pos_next;
    logic                   sat_reg,     sat_next;
    logic                   flush_reg,   flush_next;
    logic                   a_valid_reg, a_valid_next;
    logic                   a_last_reg;
    logic                   a_sat_reg;
    logic [OFFSET_BITS-1:0] a_pos_reg;

    logic                   s_accept;
    logic                   em_ready;
    logic                   em_load;
    logic                   sat_now;
    msig_pkg::scan_load_t   load_info;

    logic [7:0]             cell_in  [WINDOW_BYTES];
    logic [7:0]             cell_out [WINDOW_BYTES];
    logic [SLOTS-1:0]       cell_hit [WINDOW_BYTES];
    logic [SLOTS-1:0]       all_hit;

    assign s_ready  = !a_valid_reg || em_ready;
    assign s_accept = s_valid && s_ready;
    assign em_load  = a_valid_reg && em_ready;

    // After the final byte of a binary the chain refills from zeros.
    always_comb begin
        cell_in[0] = s_data.data_byte;
        for (int j = 1; j < WINDOW_BYTES; j++) begin
            cell_in[j] = flush_reg ? 8'h00 : cell_out[j-1];
        end
    end

    for (genvar j = 0; j < WINDOW_BYTES; j++) begin : g_cell
        msig_cell #(
            .CELL_INDEX (j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (s_accept),
            .byte_in  (cell_in[j]),
            .byte_out (cell_out[j]),
            .hit      (cell_hit[j])
        );
    end

    always_comb begin
        all_hit = '1;
        for (int j = 0; j < WINDOW_BYTES; j++) begin
            all_hit = all_hit & cell_hit[j];
        end
    end

    // A signature also needs enough bytes since the last clear and must fit the window.
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            load_info.hits[s] = (s < NUM_SIGNATURES) && enable_reg[s] && all_hit[s]
                && (int'(msig_pkg::SIG_LEN[s]) <= WINDOW_BYTES)
                && (a_pos_reg >= OFFSET_BITS'(msig_pkg::SIG_LEN[s] - 4'd1));
        end
        load_info.last = a_last_reg;
        load_info.sat  = a_sat_reg;
    end

    assign sat_now = sat_reg || (pos_reg == POS_LIMIT);

    always_comb begin
        pos_next     = pos_reg;
        sat_next     = sat_reg;
        flush_next   = flush_reg;
        a_valid_next = a_valid_reg;
        if (em_load) begin
            a_valid_next = 1'b0;
        end
        if (s_accept) begin
            a_valid_next = 1'b1;
            flush_next   = s_data.last_byte;
            if (s_data.last_byte) begin
                pos_next = '0;
                sat_next = 1'b0;
            end else begin
                sat_next = sat_now;
                if (pos_reg != POS_LIMIT) begin
                    pos_next = pos_reg + OFFSET_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 8'hFF;
            pos_reg     <= '0;
            sat_reg     <= 1'b0;
            flush_reg   <= 1'b0;
            a_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            pos_reg     <= pos_next;
            sat_reg     <= sat_next;
            flush_reg   <= flush_next;
            a_valid_reg <= a_valid_next;
        end
        if (s_accept) begin
            a_last_reg <= s_data.last_byte;
            a_sat_reg  <= sat_now;
            a_pos_reg  <= pos_reg;
        end
    end

    msig_emitter #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (a_valid_reg),
        .load_ready (em_ready),
        .load_info  (load_info),
        .load_pos   (a_pos_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: rtl/msig_checker.sv
// Port-level checker for the scanner, attached to the top level by a bind statement.
`timescale 1ns / 1ps

module msig_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input msig_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == msig_pkg::KIND_SUMMARY |-> m_data.last_result)
        else $error("summary is not the final result of its byte");

    a_summary_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == msig_pkg::KIND_SUMMARY
        |-> m_data.pattern_id == 3'd0 && m_data.match_offset == 32'd0
            && m_data.pattern_class == 2'd0)
        else $error("summary carries match fields");

    a_match_unprotected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == msig_pkg::KIND_MATCH |-> !m_data.is_protected)
        else $error("match report flags protection");

    a_version_protected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == msig_pkg::KIND_SUMMARY
        && m_data.version_code != 2'd0 |-> m_data.is_protected)
        else $error("summary reports a version without any match");

endmodule

bind masked_signature_scanner msig_checker u_msig_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/testbench.sv
// Self-checking testbench for the masked byte-signature scanner.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 60;
    localparam int SIG_COUNT     = 8;

    localparam logic [1:0] CLASS_OTHER   = 2'd0;
    localparam logic [1:0] CLASS_ENTRY   = 2'd1;
    localparam logic [1:0] CLASS_HANDLER = 2'd2;

    localparam logic [1:0] VER_NONE  = 2'd0;
    localparam logic [1:0] VER_TWO   = 2'd1;
    localparam logic [1:0] VER_THREE = 2'd2;
    localparam logic [1:0] VER_FOUR  = 2'd3;

    localparam int SIG_BYTES [SIG_COUNT] = '{9, 9, 9, 11, 11, 12, 4, 9};
    localparam logic [1:0] SIG_KIND [SIG_COUNT] = '{
        CLASS_ENTRY, CLASS_HANDLER, CLASS_ENTRY, CLASS_HANDLER,
        CLASS_ENTRY, CLASS_HANDLER, CLASS_OTHER, CLASS_OTHER
    };
    localparam logic [1:0] SIG_VER [SIG_COUNT] = '{
        VER_TWO, VER_TWO, VER_THREE, VER_THREE, VER_FOUR, VER_FOUR, VER_NONE, VER_NONE
    };
    // Signature bytes with the first byte in the top octet, padded with zeros to twelve.
    localparam logic [95:0] SIG_IMAGE [SIG_COUNT] = '{
        96'h60E80000_00005D81_ED000000,
        96'h8B442404_8B008B40_04000000,
        96'h558BEC83_EC105356_57000000,
        96'h8B45088B_008B4008_8945FC00,
        96'h4883EC28_488B0500_00000000,
        96'h488B4424_08488B00_488B4008,
        96'hDEADBEEF_00000000_00000000,
        96'h564D5072_6F746563_74000000
    };
    localparam logic [7:0] ENABLE_PLAN [7] = '{
        8'hFF, 8'h00, 8'hA5, 8'hFF, 8'h5A, 8'h00, 8'h7F
    };

    function automatic bit is_wildcard(int s, int k);
        return (s == 0 && k >= 2 && k <= 5) || (s == 4 && k >= 7 && k <= 10);
    endfunction

    function automatic logic [7:0] sig_byte(int s, int k);
        return SIG_IMAGE[s][95 - 8 * k -: 8];
    endfunction

    class scan_scoreboard;
        logic [7:0]      window [12];
        logic [31:0]     position;
        logic [7:0]      seen;
        logic            saturated;
        logic [7:0]      enable;
        msig_pkg::out_t  expected_reports [$];
        int              reports_checked;
        int              summaries_checked;
        int              mismatches;

        function new();
            enable = 8'hFF;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i]) window[i] = 8'h00;
            position  = '0;
            seen      = '0;
            saturated = 1'b0;
        endfunction

        // Window entry j holds the byte taken j transactions ago.
        function bit completes(int s);
            if (position < 32'(SIG_BYTES[s] - 1)) return 1'b0;
            for (int k = 0; k < SIG_BYTES[s]; k++) begin
                if (!is_wildcard(s, k) && window[SIG_BYTES[s] - 1 - k] != sig_byte(s, k))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(msig_pkg::in_t item);
            msig_pkg::out_t r;
            int             produced;
            logic [1:0]     ver;
            produced = 0;
            for (int i = 11; i > 0; i--) window[i] = window[i - 1];
            window[0] = item.data_byte;
            if (position == '1) saturated = 1'b1;
            for (int s = 0; s < SIG_COUNT; s++) begin
                if (enable[s] && completes(s)) begin
                    seen[s]            = 1'b1;
                    r                  = '0;
                    r.result_kind      = msig_pkg::KIND_MATCH;
                    r.pattern_id       = 3'(s);
                    r.match_offset     = position - 32'(SIG_BYTES[s] - 1);
                    r.pattern_class    = SIG_KIND[s];
                    r.version_code     = SIG_VER[s];
                    r.offset_saturated = saturated;
                    expected_reports   = {expected_reports, r};
                    produced++;
                end
            end
            if (position != '1) position++;
            if (item.last_byte) begin
                ver = VER_NONE;
                for (int s = SIG_COUNT - 1; s >= 0; s--) begin
                    if (seen[s] && SIG_VER[s] != VER_NONE) ver = SIG_VER[s];
                end
                r                  = '0;
                r.result_kind      = msig_pkg::KIND_SUMMARY;
                r.version_code     = ver;
                r.is_protected     = (seen != 0);
                r.offset_saturated = saturated;
                expected_reports   = {expected_reports, r};
                produced++;
                clear_scan();
            end
            if (produced > 0) begin
                r = expected_reports[expected_reports.size() - 1];
                r.last_result = 1'b1;
                expected_reports[expected_reports.size() - 1] = r;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(msig_pkg::out_t got);
            msig_pkg::out_t want;
            if (expected_reports.size() == 0) begin
                $error("result transaction with nothing expected: %h", got);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("pattern_id", want.pattern_id, got.pattern_id);
            compare_field("match_offset", want.match_offset, got.match_offset);
            compare_field("pattern_class", want.pattern_class, got.pattern_class);
            compare_field("version_code", want.version_code, got.version_code);
            compare_field("is_protected", want.is_protected, got.is_protected);
            compare_field("offset_saturated", want.offset_saturated, got.offset_saturated);
            compare_field("last_result", want.last_result, got.last_result);
            if (want.result_kind == msig_pkg::KIND_SUMMARY) summaries_checked++;
            else reports_checked++;
        endfunction
    endclass

    logic           aclk        = 1'b0;
    logic           aresetn     = 1'b0;
    logic           s_valid     = 1'b0;
    logic           s_ready;
    msig_pkg::in_t  s_data      = '0;
    logic           m_valid;
    logic           m_ready     = 1'b0;
    msig_pkg::out_t m_data;
    logic           cfg_wr_en   = 1'b0;
    logic [7:0]     cfg_wr_data = 8'h00;

    scan_scoreboard book;
    bit tx_calm  = 1'b0;
    bit rx_calm  = 1'b0;
    bit hold_req = 1'b0;
    int sent_items       = 0;
    int settings_written = 0;
    int blocked_cycles   = 0;
    int cycle_count      = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    masked_signature_scanner DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) book.check_report(m_data);
            if (s_valid && s_ready) book.take_byte(s_data);
            if (s_valid && !s_ready) blocked_cycles++;
        end
    end

    // Receiver: a fresh stall is drawn for every transaction; a hold request replaces it
    // with one long stretch so that the block backs up onto its input.
    initial begin : receiver
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && !hold_req);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int            gap;
        msig_pkg::in_t item;
        gap            = tx_calm ? 0 : $urandom_range(0, 19);
        item.data_byte = value;
        item.last_byte = last;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    task automatic send_image(input logic [7:0] image [$]);
        foreach (image[i]) send_byte(image[i], i == image.size() - 1);
    endtask

    function automatic void append_signature(ref logic [7:0] image [$], input int s,
                                             input bit spoil);
        logic [7:0] part [12];
        int         k;
        for (k = 0; k < SIG_BYTES[s]; k++)
            part[k] = is_wildcard(s, k) ? 8'($urandom_range(0, 255)) : sig_byte(s, k);
        // A load whose free operand is the four-byte marker completes two signatures at once.
        if (s == 4 && $urandom_range(0, 1) == 1) begin
            part[7]  = 8'hDE;
            part[8]  = 8'hAD;
            part[9]  = 8'hBE;
            part[10] = 8'hEF;
        end
        if (spoil) begin
            k = $urandom_range(0, SIG_BYTES[s] - 1);
            part[k] = part[k] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (k = 0; k < SIG_BYTES[s]; k++) image = {image, part[k]};
    endfunction

    task automatic send_binary(input bit dense);
        logic [7:0] image [$];
        int         segments;
        segments = $urandom_range(1, 4);
        repeat (segments) begin
            if (dense || $urandom_range(0, 3) != 0)
                append_signature(image, $urandom_range(0, SIG_COUNT - 1),
                                 !dense && $urandom_range(0, 4) == 0);
            else
                repeat ($urandom_range(1, 6)) image = {image, 8'($urandom_range(0, 255))};
        end
        send_image(image);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (book.expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_enable(input logic [7:0] setting);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        book.enable = setting;
        settings_written++;
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] image [$];
        logic [7:0] setting;
        int         target;
        bit         paused;
        book   = new();
        paused = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_enable(8'hFF);
        image = {8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_image(image);
        // Entry load ending in the marker: two reports on the final byte, then the summary.
        image = {8'h48, 8'h83, 8'hEC, 8'h28, 8'h48, 8'h8B, 8'h05,
                 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_image(image);
        // A marker split across two binaries must not be found.
        image = {8'hDE, 8'hAD, 8'hBE};
        send_image(image);
        image = {8'hEF};
        send_image(image);
        write_enable(8'hBF);
        image = {8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_image(image);

        for (int phase = 0; phase < 7; phase++) begin
            setting = (phase == 5) ? 8'($urandom) : ENABLE_PLAN[phase];
            write_enable(setting);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                tx_calm  = 1'b1;
                hold_req = 1'b1;
            end
            target = sent_items + PHASE_BYTES;
            while (sent_items < target) begin
                send_binary(phase == 3);
                if (phase == 4 && !paused) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        $display("tb: %0d bytes scanned, %0d match reports and %0d summaries checked",
                 sent_items, book.reports_checked, book.summaries_checked);
        $display("tb: %0d enable settings, input held off by the block for %0d cycles",
                 settings_written, blocked_cycles);
        if (book.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
